### design/servo_led_tick_sequencer_top_assert.svh
// Assertion macros for the servo/LED tick sequencer.
// Include this file inside a module body; it depends on nothing else.
`ifndef SERVO_LED_TICK_SEQUENCER_TOP_ASSERT_SVH
`define SERVO_LED_TICK_SEQUENCER_TOP_ASSERT_SVH

// Checks cons in the same cycle as ante, outside of reset.
`define SLTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante, outside of reset.
`define SLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/slts_pkg.sv
// Shared types and constants for the servo/LED tick sequencer.
// No dependencies; the core, result register and top level files import this package.
`timescale 1ns / 1ps
`default_nettype none

package slts_pkg;

  localparam int COMPARE_WIDTH = 16;
  localparam int CMP_EXT_W     = (COMPARE_WIDTH > 16) ? COMPARE_WIDTH : 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [COMPARE_WIDTH-1:0] SWEEP_HIGH = COMPARE_WIDTH'(32'h1BF);
  localparam logic [COMPARE_WIDTH-1:0] SWEEP_LOW  = COMPARE_WIDTH'(32'h66);
  localparam logic [COMPARE_WIDTH-1:0] STEP       = COMPARE_WIDTH'(32'd7);

  localparam logic [3:0] COLOR_END = 4'h8;
  localparam logic [3:0] UP_END    = 4'd11;
  localparam logic [4:0] DOWN_TOP  = 5'd10;
  localparam logic [4:0] DOWN_DONE = 5'h1F;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [2:0] {
    MODE_SWEEP      = 3'd0,
    MODE_IDLE       = 3'd1,
    MODE_SCAN       = 3'd2,
    MODE_BLINK      = 3'd3,
    MODE_COUNT_UP   = 3'd4,
    MODE_COUNT_DOWN = 3'd5
  } slts_mode_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  mode_select;
    logic [15:0] value_a;
    logic [15:0] value_b;
  } slts_item_t;

  typedef struct packed {
    logic [15:0] servo_compare;
    logic [2:0]  led_color;
    logic        led_lit;
    logic        number_valid;
    logic [3:0]  shown_number;
    logic [15:0] repeats_left;
    logic        busy_res;
  } slts_result_t;

endpackage

`default_nettype wire

### design/slts_core.sv
// Sequencer state registers and the single-pass next-state logic for one item.
// Depends on slts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module slts_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  slts_pkg::slts_item_t  item,
  output slts_pkg::slts_result_t result
);
  import slts_pkg::*;

  `include "servo_led_tick_sequencer_top_assert.svh"

  logic [COMPARE_WIDTH-1:0] compare_r, compare_nxt;
  logic                     sweep_r, sweep_nxt;
  slts_mode_t               mode_r, mode_nxt;
  logic                     scan_rising_r, scan_rising_nxt;
  logic [15:0]              scan_target_r, scan_target_nxt;
  logic [15:0]              repeat_r, repeat_nxt;
  logic [3:0]               blink_color_r, blink_color_nxt;
  logic                     blink_phase_r, blink_phase_nxt;
  logic [3:0]               up_r, up_nxt;
  logic [4:0]               down_r, down_nxt;
  logic [3:0]               led_r, led_nxt;

  logic [COMPARE_WIDTH-1:0] cmp_up, cmp_dn;
  logic [CMP_EXT_W-1:0]     up_ext, dn_ext, target_ext;
  logic [15:0]              rep_spent;
  logic [3:0]               blink_base;
  logic [3:0]               shown_led;
  logic                     num_valid;
  logic [3:0]               num;
  logic                     led_off_after;

  assign cmp_up     = compare_r + STEP;
  assign cmp_dn     = compare_r - STEP;
  assign up_ext     = CMP_EXT_W'(cmp_up);
  assign dn_ext     = CMP_EXT_W'(cmp_dn);
  assign target_ext = CMP_EXT_W'(scan_target_r);
  assign rep_spent  = (repeat_r != 16'd0) ? (repeat_r - 16'd1) : repeat_r;

  always_comb begin
    compare_nxt     = compare_r;
    sweep_nxt       = sweep_r;
    mode_nxt        = mode_r;
    scan_rising_nxt = scan_rising_r;
    scan_target_nxt = scan_target_r;
    repeat_nxt      = repeat_r;
    blink_color_nxt = blink_color_r;
    blink_phase_nxt = blink_phase_r;
    up_nxt          = up_r;
    down_nxt        = down_r;
    led_nxt         = led_r;
    blink_base      = blink_color_r;
    shown_led       = led_r;
    num_valid       = 1'b0;
    num             = 4'd0;
    led_off_after   = 1'b0;

    if (item.req_type == REQ_LOAD) begin
      case (item.mode_select)
        MODE_SWEEP: begin
          mode_nxt = MODE_SWEEP;
        end
        MODE_SCAN: begin
          mode_nxt        = MODE_SCAN;
          compare_nxt     = COMPARE_WIDTH'(item.value_a);
          scan_target_nxt = item.value_b;
          scan_rising_nxt = (item.value_a < item.value_b);
        end
        MODE_BLINK, MODE_COUNT_UP, MODE_COUNT_DOWN: begin
          repeat_nxt = item.value_a;
          mode_nxt   = (item.value_a == 16'd0) ? MODE_IDLE : slts_mode_t'(item.mode_select);
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end else begin
      case (mode_r)
        MODE_SWEEP: begin
          if (sweep_r) begin
            compare_nxt = cmp_up;
            if (cmp_up >= SWEEP_HIGH) sweep_nxt = 1'b0;
          end else begin
            compare_nxt = cmp_dn;
            if (cmp_dn <= SWEEP_LOW) sweep_nxt = 1'b1;
          end
        end
        MODE_SCAN: begin
          if (scan_rising_r) begin
            compare_nxt = cmp_up;
            if (up_ext >= target_ext) mode_nxt = MODE_IDLE;
          end else begin
            compare_nxt = cmp_dn;
            if (dn_ext <= target_ext) mode_nxt = MODE_IDLE;
          end
        end
        MODE_BLINK: begin
          if (!blink_phase_r) begin
            blink_phase_nxt = 1'b1;
            // A finished color cycle wraps the color and spends one repeat.
            if (blink_color_r >= COLOR_END) begin
              blink_base = 4'd0;
              repeat_nxt = rep_spent;
              if (rep_spent == 16'd0) mode_nxt = MODE_IDLE;
            end
            led_nxt         = {1'b1, blink_base[2:0]};
            blink_color_nxt = blink_base + 4'd1;
            led_off_after   = (mode_nxt != MODE_BLINK);
          end else begin
            led_nxt         = 4'd0;
            blink_phase_nxt = 1'b0;
          end
        end
        MODE_COUNT_UP: begin
          led_nxt = 4'd0;
          if (up_r >= UP_END) begin
            up_nxt     = 4'd0;
            repeat_nxt = rep_spent;
            if (rep_spent == 16'd0) mode_nxt = MODE_IDLE;
          end else begin
            num_valid = 1'b1;
            num       = up_r;
            up_nxt    = up_r + 4'd1;
          end
        end
        MODE_COUNT_DOWN: begin
          led_nxt = 4'd0;
          if (down_r > DOWN_TOP) begin
            down_nxt   = DOWN_TOP;
            repeat_nxt = rep_spent;
            if (rep_spent == 16'd0) mode_nxt = MODE_IDLE;
          end else begin
            num_valid = 1'b1;
            num       = down_r[3:0];
            down_nxt  = (down_r == 5'd0) ? DOWN_DONE : (down_r - 5'd1);
          end
        end
        default: begin
        end
      endcase
      // The tick result shows the LED as set by this step; a blink that
      // just ended is switched off only afterwards.
      shown_led = led_nxt;
      if (led_off_after) led_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r     <= SWEEP_LOW;
      sweep_r       <= 1'b0;
      mode_r        <= MODE_SWEEP;
      scan_rising_r <= 1'b0;
      scan_target_r <= 16'd0;
      repeat_r      <= 16'd0;
      blink_color_r <= 4'd0;
      blink_phase_r <= 1'b0;
      up_r          <= 4'd0;
      down_r        <= DOWN_TOP;
      led_r         <= 4'd0;
    end else if (step) begin
      compare_r     <= compare_nxt;
      sweep_r       <= sweep_nxt;
      mode_r        <= mode_nxt;
      scan_rising_r <= scan_rising_nxt;
      scan_target_r <= scan_target_nxt;
      repeat_r      <= repeat_nxt;
      blink_color_r <= blink_color_nxt;
      blink_phase_r <= blink_phase_nxt;
      up_r          <= up_nxt;
      down_r        <= down_nxt;
      led_r         <= led_nxt;
    end
  end

  assign result.servo_compare = 16'(compare_nxt);
  assign result.led_color     = shown_led[3] ? shown_led[2:0] : 3'd0;
  assign result.led_lit       = shown_led[3];
  assign result.number_valid  = num_valid;
  assign result.shown_number  = num;
  assign result.repeats_left  = repeat_nxt;
  assign result.busy_res      = (mode_nxt inside {[MODE_SCAN:MODE_COUNT_DOWN]});

  `SLTS_ASSERT_SAME(a_number_only_when_counting, clk, rst_n,
    step && result.number_valid,
    (mode_r == MODE_COUNT_UP) || (mode_r == MODE_COUNT_DOWN),
    "shown number outside a count mode")
  `SLTS_ASSERT_NEXT(a_idle_tick_holds_compare, clk, rst_n,
    step && (item.req_type == REQ_TICK) && (mode_r == MODE_IDLE),
    compare_r == $past(compare_r),
    "idle tick moved the compare value")
  `SLTS_ASSERT_NEXT(a_tick_never_adds_repeats, clk, rst_n,
    step && (item.req_type == REQ_TICK),
    repeat_r <= $past(repeat_r),
    "tick increased the repeat count")
  `SLTS_ASSERT_NEXT(a_blink_off_phase_clears_led, clk, rst_n,
    step && (item.req_type == REQ_TICK) && (mode_r == MODE_BLINK) && blink_phase_r,
    (led_r == 4'd0) && !blink_phase_r,
    "blink off phase left the LED on")

endmodule

`default_nettype wire

### design/slts_out_stage.sv
// Result register of the sequencer: holds one packed result until the
// downstream transfer completes. Depends on slts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slts_out_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  slts_pkg::slts_result_t               result,
  output logic                                 can_take,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0 up: servo_compare, led_color, led_lit, number_valid,
  // shown_number, repeats_left, busy_res, zero padding.
  output logic [slts_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import slts_pkg::*;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign can_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= OUT_TDATA_W'({result.busy_res, result.repeats_left, result.shown_number,
                                  result.number_valid, result.led_lit, result.led_color,
                                  result.servo_compare});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### design/servo_led_tick_sequencer_top.sv
// Servo/LED tick sequencer top level: input register, sequencer core and result register.
// An item passes the input register, then the result register, before its result appears.
// Throughput: one item per cycle (single-pass step logic) unless out_tready stalls it.
// Reset (rst_n low, synchronous): both stages empty, compare value 0x66, free sweep mode.
// Depends on slts_pkg, slts_core and slts_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module servo_led_tick_sequencer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0 up: mode_select, value_a, value_b, zero padding.
  input  logic [slts_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0 up: req_type.
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0 up: servo_compare, led_color, led_lit, number_valid,
  // shown_number, repeats_left, busy_res, zero padding.
  output logic [slts_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import slts_pkg::*;

  logic         in_valid_r;
  slts_item_t   in_item_r;
  logic         can_take;
  logic         advance;
  slts_result_t result;

  // An item moves from the input register into the result register when
  // the result register is empty or being drained in the same cycle.
  assign advance   = in_valid_r && can_take;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.req_type    <= in_tuser;
      in_item_r.mode_select <= in_tdata[2:0];
      in_item_r.value_a     <= in_tdata[18:3];
      in_item_r.value_b     <= in_tdata[34:19];
    end
  end

  slts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (result)
  );

  slts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for servo_led_tick_sequencer_top: directed and random mode
// loads and ticks on the input stream, each result checked against a built-in predictor.
// Depends on slts_pkg and the servo_led_tick_sequencer_top RTL.

module testbench;
  import slts_pkg::*;

  localparam int  CW           = COMPARE_WIDTH;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  RANDOM_ITEMS = 1600;
  localparam int  DRAIN_CYCLES = 10;
  localparam int  IDLE_PCT     = 36;
  localparam int  STEADY_FIRST = 900;
  localparam int  STEADY_LAST  = 1150;

  localparam logic [CW-1:0] SWEEP_TOP    = CW'(16'h1BF);
  localparam logic [CW-1:0] SWEEP_BOTTOM = CW'(16'h66);
  localparam logic [CW-1:0] SERVO_STEP   = CW'(16'd7);
  localparam logic [3:0]    BLINK_COLORS = 4'd8;
  localparam logic [3:0]    UP_WRAP      = 4'd11;
  localparam logic [4:0]    DOWN_START   = 5'd10;
  localparam logic [4:0]    DOWN_SPENT   = 5'h1F;
  localparam logic [2:0]    MODE_SPARE_6 = 3'd6;
  localparam logic [2:0]    MODE_SPARE_7 = 3'd7;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  servo_led_tick_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted sequencer state.
  logic [CW-1:0] servo_cmp;
  logic          sweep_up;
  slts_mode_t    cur_mode;
  logic          scan_up;
  logic [15:0]   scan_goal;
  logic [15:0]   repeats;
  logic [3:0]    blink_idx;
  logic          blink_off_phase;
  logic [3:0]    up_num;
  logic [4:0]    down_num;
  logic [3:0]    led_reg;

  slts_item_t   pending_items[$];
  slts_result_t expected_results[$];

  int items_queued    = 0;
  int items_accepted  = 0;
  int loads_accepted  = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int runs_finished   = 0;
  int scans_finished  = 0;
  int cycle_count     = 0;
  int load_hits[8];

  logic       steady;
  slts_item_t drv_item;

  assign steady = (items_accepted >= STEADY_FIRST) && (items_accepted < STEADY_LAST);

  task automatic spend_one_repeat();
    if (repeats != 16'd0)
      repeats = repeats - 16'd1;
    if (repeats == 16'd0) begin
      cur_mode = MODE_IDLE;
      runs_finished++;
    end
  endtask

  task automatic step_sequencer(input slts_item_t it, output slts_result_t r);
    logic [3:0] shown;
    logic       num_valid;
    logic [3:0] num;
    logic       off_after;
    num_valid = 1'b0;
    num       = 4'd0;
    off_after = 1'b0;
    if (it.req_type == REQ_LOAD) begin
      case (it.mode_select)
        MODE_SWEEP: cur_mode = MODE_SWEEP;
        MODE_SCAN: begin
          cur_mode  = MODE_SCAN;
          servo_cmp = CW'(it.value_a);
          scan_goal = it.value_b;
          scan_up   = (it.value_a < it.value_b);
        end
        MODE_BLINK, MODE_COUNT_UP, MODE_COUNT_DOWN: begin
          repeats  = it.value_a;
          cur_mode = (it.value_a == 16'd0) ? MODE_IDLE : slts_mode_t'(it.mode_select);
        end
        default: cur_mode = MODE_IDLE;
      endcase
    end else begin
      case (cur_mode)
        MODE_SWEEP: begin
          if (sweep_up) begin
            servo_cmp = servo_cmp + SERVO_STEP;
            if (servo_cmp >= SWEEP_TOP)
              sweep_up = 1'b0;
          end else begin
            servo_cmp = servo_cmp - SERVO_STEP;
            if (servo_cmp <= SWEEP_BOTTOM)
              sweep_up = 1'b1;
          end
        end
        MODE_SCAN: begin
          if (scan_up) begin
            servo_cmp = servo_cmp + SERVO_STEP;
            if (servo_cmp >= scan_goal)
              cur_mode = MODE_IDLE;
          end else begin
            servo_cmp = servo_cmp - SERVO_STEP;
            if (servo_cmp <= scan_goal)
              cur_mode = MODE_IDLE;
          end
          if (cur_mode == MODE_IDLE)
            scans_finished++;
        end
        MODE_BLINK: begin
          if (!blink_off_phase) begin
            blink_off_phase = 1'b1;
            if (blink_idx >= BLINK_COLORS) begin
              blink_idx = 4'd0;
              spend_one_repeat();
            end
            led_reg   = {1'b1, blink_idx[2:0]};
            blink_idx = blink_idx + 4'd1;
            // The last color of a run is shown once, then the LED goes dark.
            if (cur_mode != MODE_BLINK)
              off_after = 1'b1;
          end else begin
            led_reg         = 4'd0;
            blink_off_phase = 1'b0;
          end
        end
        MODE_COUNT_UP: begin
          led_reg = 4'd0;
          if (up_num >= UP_WRAP) begin
            up_num = 4'd0;
            spend_one_repeat();
          end else begin
            num_valid = 1'b1;
            num       = up_num;
            up_num    = up_num + 4'd1;
          end
        end
        MODE_COUNT_DOWN: begin
          led_reg = 4'd0;
          if (down_num > DOWN_START) begin
            down_num = DOWN_START;
            spend_one_repeat();
          end else begin
            num_valid = 1'b1;
            num       = down_num[3:0];
            down_num  = (down_num == 5'd0) ? DOWN_SPENT : down_num - 5'd1;
          end
        end
        default: ;
      endcase
    end
    shown = led_reg;
    if (off_after)
      led_reg = 4'd0;
    r.servo_compare = servo_cmp[15:0];
    r.led_color     = shown[3] ? shown[2:0] : 3'd0;
    r.led_lit       = shown[3];
    r.number_valid  = num_valid;
    r.shown_number  = num;
    r.repeats_left  = repeats;
    r.busy_res      = (cur_mode >= MODE_SCAN) && (cur_mode <= MODE_COUNT_DOWN);
  endtask

  function automatic slts_item_t make_item(logic req, logic [2:0] sel, logic [15:0] va,
                                           logic [15:0] vb);
    slts_item_t it;
    it.req_type    = req;
    it.mode_select = sel;
    it.value_a     = va;
    it.value_b     = vb;
    return it;
  endfunction

  task automatic queue_item(input slts_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_load(input logic [2:0] sel, input logic [15:0] va, input logic [15:0] vb);
    queue_item(make_item(REQ_LOAD, sel, va, vb));
  endtask

  // Tick payload fields are ignored by the block, so they carry random bits.
  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++)
      queue_item(make_item(REQ_TICK, 3'($urandom_range(7)), 16'($urandom), 16'($urandom)));
  endtask

  // Input side: one transfer per handshake, random gaps between items outside the steady window.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        slts_result_t r;
        step_sequencer(drv_item, r);
        expected_results.push_back(r);
        items_accepted++;
        if (drv_item.req_type == REQ_LOAD) begin
          loads_accepted++;
          load_hits[drv_item.mode_select]++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          drv_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drv_item.req_type;
          in_tdata  <= IN_TDATA_W'({drv_item.value_b, drv_item.value_a,
                                    drv_item.mode_select});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure outside the steady window, each transfer checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        slts_result_t got;
        slts_result_t want;
        got.servo_compare = out_tdata[15:0];
        got.led_color     = out_tdata[18:16];
        got.led_lit       = out_tdata[19];
        got.number_valid  = out_tdata[20];
        got.shown_number  = out_tdata[24:21];
        got.repeats_left  = out_tdata[40:25];
        got.busy_res      = out_tdata[41];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result %h at cycle %0d", got, cycle_count);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d mismatch at cycle %0d", results_checked, cycle_count);
              $display("  expected cmp=%h color=%0d lit=%b nv=%b num=%0d rep=%0d busy=%b",
                       want.servo_compare, want.led_color, want.led_lit, want.number_valid,
                       want.shown_number, want.repeats_left, want.busy_res);
              $display("  actual   cmp=%h color=%0d lit=%b nv=%b num=%0d rep=%0d busy=%b",
                       got.servo_compare, got.led_color, got.led_lit, got.number_valid,
                       got.shown_number, got.repeats_left, got.busy_res);
            end
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d results outstanding", expected_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int random_count;
    int kind;
    int reps;
    int n;
    logic [15:0] start;
    servo_cmp       = SWEEP_BOTTOM;
    sweep_up        = 1'b0;
    cur_mode        = MODE_SWEEP;
    scan_up         = 1'b0;
    scan_goal       = 16'd0;
    repeats         = 16'd0;
    blink_idx       = 4'd0;
    blink_off_phase = 1'b0;
    up_num          = 4'd0;
    down_num        = DOWN_START;
    led_reg         = 4'd0;
    foreach (load_hits[i])
      load_hits[i] = 0;

    // Directed part: sweep turnaround, scan with equal ends, compare wrap both ways,
    // unused mode codes, zero repeat loads and the largest repeat count.
    queue_ticks(2);
    queue_load(MODE_SCAN, 16'h0100, 16'h0100);
    queue_ticks(2);
    queue_load(MODE_SCAN, 16'hFFFD, 16'hFFFF);
    queue_ticks(1);
    queue_load(MODE_SCAN, 16'h0003, 16'h0000);
    queue_ticks(1);
    queue_load(MODE_SWEEP, 16'hFFFF, 16'hFFFF);
    queue_ticks(1);
    queue_load(MODE_SPARE_6, 16'h0000, 16'h0000);
    queue_load(MODE_SPARE_7, 16'hFFFF, 16'hFFFF);
    queue_ticks(1);
    queue_load(MODE_BLINK, 16'h0000, 16'h5A5A);
    queue_load(MODE_COUNT_UP, 16'h0000, 16'hA5A5);
    queue_load(MODE_COUNT_DOWN, 16'h0000, 16'h0000);
    queue_load(MODE_BLINK, 16'hFFFF, 16'hFFFF);
    queue_ticks(2);
    queue_load(MODE_COUNT_UP, 16'd2, 16'd0);
    queue_ticks(1);
    queue_load(MODE_COUNT_DOWN, 16'd1, 16'd0);
    queue_ticks(1);
    queue_load(MODE_IDLE, 16'h1234, 16'h4321);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Hold the sender back until the directed part has fully drained.
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(posedge clk);

    random_count = items_queued;
    while (items_queued - random_count < RANDOM_ITEMS) begin
      kind = $urandom_range(9);
      case (kind)
        0: begin
          queue_load(MODE_SWEEP, 16'($urandom), 16'($urandom));
          queue_ticks($urandom_range(1, 40));
        end
        1: begin
          start = 16'($urandom_range(16'h66, 16'h1BF));
          n = $urandom_range(0, 60);
          queue_load(MODE_SCAN, start, $urandom_range(1) ? start + 16'(n) : start - 16'(n));
          queue_ticks($urandom_range(0, 12));
        end
        2, 3: begin
          reps = $urandom_range(1, 3);
          queue_load(MODE_BLINK, 16'(reps), 16'($urandom));
          n = ($urandom_range(3) == 0) ? $urandom_range(0, reps * 16)
                                       : reps * 16 + $urandom_range(1, 18);
          queue_ticks(n);
        end
        4, 5: begin
          reps = $urandom_range(1, 3);
          queue_load(($urandom_range(1) != 0) ? MODE_COUNT_UP : MODE_COUNT_DOWN,
                     16'(reps), 16'($urandom));
          n = ($urandom_range(3) == 0) ? $urandom_range(0, reps * 12)
                                       : reps * 12 + $urandom_range(0, 13);
          queue_ticks(n);
        end
        6: begin
          case ($urandom_range(2))
            0: queue_load(MODE_IDLE, 16'($urandom), 16'($urandom));
            1: queue_load(MODE_SPARE_6, 16'($urandom), 16'($urandom));
            default: queue_load(MODE_SPARE_7, 16'($urandom), 16'($urandom));
          endcase
          queue_ticks($urandom_range(0, 3));
        end
        7: begin
          queue_load(MODE_SCAN, 16'($urandom), 16'($urandom));
          queue_ticks($urandom_range(0, 8));
        end
        8: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            queue_item(make_item(1'($urandom_range(1)), 3'($urandom_range(7)),
                                 16'($urandom), 16'($urandom)));
        end
        default: begin
          queue_load(3'($urandom_range(7)), 16'($urandom), 16'($urandom));
          queue_ticks($urandom_range(0, 5));
        end
      endcase
    end

    while (items_accepted != items_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_results.size();

    $display("Summary: %0d items (%0d loads, %0d ticks), %0d results checked, %0d mismatches",
             items_accepted, loads_accepted, items_accepted - loads_accepted, results_checked,
             mismatches);
    $display("Loads per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; runs spent %0d, scans %0d",
             load_hits[0], load_hits[1], load_hits[2], load_hits[3], load_hits[4],
             load_hits[5], load_hits[6], load_hits[7], runs_finished, scans_finished);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/slts_pkg.sv
design/slts_core.sv
design/slts_out_stage.sv
design/servo_led_tick_sequencer_top.sv
tb/sv/testbench.sv
